// ===== sv/dmarb_pkg.sv =====
// ============================================================================
// dmarb_pkg
// Shared types and constants of the four-channel DMA register block.
// ============================================================================
package dmarb_pkg;

    localparam int CHANNELS = 4;

    // Register offsets outside the per-channel window.
    localparam logic [6:0] STATUS_ADDR  = 7'h40;
    localparam logic [6:0] ARBITER_ADDR = 7'h48;

    // Per-channel register index, bits 3:0 of the offset.
    localparam logic [3:0] REG_CONTROL = 4'd0;
    localparam logic [3:0] REG_COUNT   = 4'd1;
    localparam logic [3:0] REG_SRC_HI  = 4'd3;
    localparam logic [3:0] REG_SRC_LO  = 4'd4;
    localparam logic [3:0] REG_DST_HI  = 4'd5;
    localparam logic [3:0] REG_DST_LO  = 4'd6;

    // Bus access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Control word bit positions.
    localparam int CTL_ENABLE    = 31;
    localparam int CTL_TERMINAL  = 30;
    localparam int CTL_DONE_IRQ  = 29;
    localparam int CTL_ERROR_IRQ = 28;
    localparam int CTL_WIDTH_LSB = 25;

    localparam int COUNT_W = 20;
    localparam int BYTES_W = 27;

    typedef struct packed {
        logic        command;
        logic [6:0]  reg_addr;
        logic [31:0] write_data;
        logic        transfer_ok;
    } access_t;

    typedef struct packed {
        logic [31:0]        read_data;
        logic               copy_request;
        logic [63:0]        copy_source;
        logic [63:0]        copy_dest;
        logic [BYTES_W-1:0] copy_bytes;
        logic [3:0]         irq_lines;
    } result_t;

endpackage

// ===== sv/dmarb_regs.sv =====
// ============================================================================
// dmarb_regs
// Channel and global registers, access decode, transfer start and the
// combinational result of the access held in the input register.
// ============================================================================
module dmarb_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dmarb_pkg::access_t acc,
    output dmarb_pkg::result_t res
);

    logic [31:0]                   chan_ctl_reg   [dmarb_pkg::CHANNELS];
    logic [dmarb_pkg::COUNT_W-1:0] xfer_count_reg [dmarb_pkg::CHANNELS];
    logic [63:0]                   src_reg   [dmarb_pkg::CHANNELS];
    logic [63:0]                   dst_reg   [dmarb_pkg::CHANNELS];
    logic [dmarb_pkg::CHANNELS-1:0] done_reg;
    logic [dmarb_pkg::CHANNELS-1:0] err_reg;
    logic [1:0]                    arb_reg;
    logic [dmarb_pkg::CHANNELS-1:0] irq_reg;

    logic [31:0]                   chan_ctl_next   [dmarb_pkg::CHANNELS];
    logic [dmarb_pkg::COUNT_W-1:0] xfer_count_next [dmarb_pkg::CHANNELS];
    logic [63:0]                   src_next   [dmarb_pkg::CHANNELS];
    logic [63:0]                   dst_next   [dmarb_pkg::CHANNELS];
    logic [dmarb_pkg::CHANNELS-1:0] done_next;
    logic [dmarb_pkg::CHANNELS-1:0] err_next;
    logic [1:0]                    arb_next;
    logic [dmarb_pkg::CHANNELS-1:0] irq_next;

    logic [1:0]  ch;
    logic [3:0]  rsel;
    logic        in_chan;
    logic        is_write;
    logic        start;
    logic [2:0]  width;
    logic [6:0]  align_mask;
    logic        aligned;
    logic        copy_ok;
    logic [dmarb_pkg::BYTES_W-1:0] bytes;
    logic [31:0] status_view;
    logic [31:0] ctrl_new;
    logic [31:0] rd;

    assign ch       = acc.reg_addr[5:4];
    assign rsel     = acc.reg_addr[3:0];
    assign is_write = (acc.command == dmarb_pkg::CMD_WRITE);
    assign in_chan  = !acc.reg_addr[6] && (32'(ch) < 32'(dmarb_pkg::CHANNELS));

    assign width      = acc.write_data[dmarb_pkg::CTL_WIDTH_LSB +: 3];
    assign align_mask = (7'd1 << width) - 7'd1;
    assign aligned    = ((src_reg[ch][6:0] & align_mask) == 7'd0) &&
                        ((dst_reg[ch][6:0] & align_mask) == 7'd0);
    assign copy_ok    = aligned && acc.transfer_ok;
    assign bytes      = {{(dmarb_pkg::BYTES_W - dmarb_pkg::COUNT_W){1'b0}},
                         xfer_count_reg[ch]} << width;
    assign ctrl_new   = {1'b0, acc.write_data[30:0]};

    assign start = in_chan && is_write && (rsel == dmarb_pkg::REG_CONTROL) &&
                   acc.write_data[dmarb_pkg::CTL_ENABLE] &&
                   acc.write_data[dmarb_pkg::CTL_TERMINAL] &&
                   !done_reg[ch] && !err_reg[ch];

    // Status layout: done of channel i at bit 31-i, error at bit 27-4i.
    always_comb
    begin
        status_view = 32'd0;
        for (int i = 0; i < dmarb_pkg::CHANNELS; i++)
        begin
            status_view[31 - i]     = done_reg[i];
            status_view[27 - 4 * i] = err_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < dmarb_pkg::CHANNELS; i++)
        begin
            chan_ctl_next[i]   = chan_ctl_reg[i];
            xfer_count_next[i] = xfer_count_reg[i];
            src_next[i]        = src_reg[i];
            dst_next[i]        = dst_reg[i];
        end
        done_next = done_reg;
        err_next  = err_reg;
        arb_next  = arb_reg;
        irq_next  = irq_reg;

        if (is_write && in_chan)
        begin
            unique case (rsel)
                dmarb_pkg::REG_CONTROL:
                begin
                    chan_ctl_next[ch] = acc.write_data;
                    if (start)
                    begin
                        if (copy_ok)
                        begin
                            src_next[ch]        = src_reg[ch] + 64'(bytes);
                            dst_next[ch]        = dst_reg[ch] + 64'(bytes);
                            xfer_count_next[ch] = '0;
                            done_next[ch]       = 1'b1;
                        end
                        else
                        begin
                            err_next[ch] = 1'b1;
                        end
                        chan_ctl_next[ch] = ctrl_new;
                        irq_next[ch]  = (ctrl_new[dmarb_pkg::CTL_TERMINAL] &&
                                         ctrl_new[dmarb_pkg::CTL_DONE_IRQ] &&
                                         done_next[ch]) ||
                                        (err_next[ch] && ctrl_new[dmarb_pkg::CTL_ERROR_IRQ]);
                    end
                end
                dmarb_pkg::REG_COUNT:
                    xfer_count_next[ch] = acc.write_data[dmarb_pkg::COUNT_W-1:0];
                dmarb_pkg::REG_SRC_HI: src_next[ch][63:32] = acc.write_data;
                dmarb_pkg::REG_SRC_LO: src_next[ch][31:0]  = acc.write_data;
                dmarb_pkg::REG_DST_HI: dst_next[ch][63:32] = acc.write_data;
                dmarb_pkg::REG_DST_LO: dst_next[ch][31:0]  = acc.write_data;
                default: ;
            endcase
        end
        else if (is_write && (acc.reg_addr == dmarb_pkg::STATUS_ADDR))
        begin
            // Write-one-to-clear; a channel's interrupt is re-evaluated only
            // when its done bit is written.
            for (int i = 0; i < dmarb_pkg::CHANNELS; i++)
            begin
                done_next[i] = done_reg[i] & !acc.write_data[31 - i];
                err_next[i]  = err_reg[i] & !acc.write_data[27 - 4 * i];
            end
            for (int i = 0; i < dmarb_pkg::CHANNELS; i++)
            begin
                if (acc.write_data[31 - i])
                begin
                    irq_next[i] = (chan_ctl_reg[i][dmarb_pkg::CTL_TERMINAL] &&
                                   chan_ctl_reg[i][dmarb_pkg::CTL_DONE_IRQ] &&
                                   done_next[i]) ||
                                  (err_next[i] && chan_ctl_reg[i][dmarb_pkg::CTL_ERROR_IRQ]);
                end
            end
        end
        else if (is_write && (acc.reg_addr == dmarb_pkg::ARBITER_ADDR))
        begin
            arb_next = acc.write_data[31:30];
        end
    end

    always_comb
    begin
        rd = 32'd0;
        if (!is_write)
        begin
            if (in_chan)
            begin
                unique case (rsel)
                    dmarb_pkg::REG_CONTROL: rd = chan_ctl_reg[ch];
                    dmarb_pkg::REG_COUNT:   rd = 32'(xfer_count_reg[ch]);
                    dmarb_pkg::REG_SRC_HI:  rd = src_reg[ch][63:32];
                    dmarb_pkg::REG_SRC_LO:  rd = src_reg[ch][31:0];
                    dmarb_pkg::REG_DST_HI:  rd = dst_reg[ch][63:32];
                    dmarb_pkg::REG_DST_LO:  rd = dst_reg[ch][31:0];
                    default:                rd = 32'd0;
                endcase
            end
            else if (acc.reg_addr == dmarb_pkg::STATUS_ADDR)
            begin
                rd = status_view;
            end
            else if (acc.reg_addr == dmarb_pkg::ARBITER_ADDR)
            begin
                rd = {arb_reg, 30'd0};
            end
        end
    end

    always_comb
    begin
        res.read_data    = rd;
        res.copy_request = start && copy_ok;
        res.copy_source  = (start && copy_ok) ? src_reg[ch] : 64'd0;
        res.copy_dest    = (start && copy_ok) ? dst_reg[ch] : 64'd0;
        res.copy_bytes   = (start && copy_ok) ? bytes : '0;
        res.irq_lines    = 4'(irq_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dmarb_pkg::CHANNELS; i++)
            begin
                chan_ctl_reg[i]   <= '0;
                xfer_count_reg[i] <= '0;
                src_reg[i]        <= '0;
                dst_reg[i]        <= '0;
            end
            done_reg <= '0;
            err_reg  <= '0;
            arb_reg  <= '0;
            irq_reg  <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < dmarb_pkg::CHANNELS; i++)
            begin
                chan_ctl_reg[i]   <= chan_ctl_next[i];
                xfer_count_reg[i] <= xfer_count_next[i];
                src_reg[i]        <= src_next[i];
                dst_reg[i]        <= dst_next[i];
            end
            done_reg <= done_next;
            err_reg  <= err_next;
            arb_reg  <= arb_next;
            irq_reg  <= irq_next;
        end
    end

endmodule

// ===== sv/four_channel_dma_register_block_unit.sv =====
// ============================================================================
// four_channel_dma_register_block_unit
// Bus-access front end of a four-channel memory-to-memory DMA controller.
// ============================================================================
//
//  Channel | Direction | Carries
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | one register read or write, with memory accept flag
//  m_*     | out       | read data, copy request and interrupt levels
//
//  Each access is held in the input register and its result then sits in the
//  output register, one transfer per cycle while the output is not stalled.
//  The register update and the 64-bit address advance happen in the
//  combinational logic between the two registers.
//  Reset clears all channel and global registers and both valid flags.
//  A stalled output holds its result and the input register keeps the next
//  access, so the input stalls only when both stages are full.
//
module four_channel_dma_register_block_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // reg_addr[6:0], write_data[38:7], transfer_ok[39]
    input  logic         s_tuser,   // command[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata    // read_data[31:0], copy_request[32],
                                    // copy_source[96:33], copy_dest[160:97],
                                    // copy_bytes[187:161], irq_lines[191:188]
);

    logic               in_valid_reg;
    dmarb_pkg::access_t in_data_reg;
    logic               out_valid_reg;
    dmarb_pkg::result_t out_data_reg;
    dmarb_pkg::result_t res;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.irq_lines, out_data_reg.copy_bytes,
                       out_data_reg.copy_dest, out_data_reg.copy_source,
                       out_data_reg.copy_request, out_data_reg.read_data};

    dmarb_regs u_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .acc   (in_data_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg.command     <= s_tuser;
            in_data_reg.reg_addr    <= s_tdata[6:0];
            in_data_reg.write_data  <= s_tdata[38:7];
            in_data_reg.transfer_ok <= s_tdata[39];
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    // The input stalls only when both the input and output stages are full.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    // A processed access always produces a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed access left no result");

    // A copy is only issued by a write, so its read data is zero.
    a_copy_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0))
        else $error("copy request carried read data");

endmodule
